// ----- sv/eesc_pkg.sv -----
// shared types and constants for the earliest expiry stock consumer
package eesc_pkg;

    localparam int CNT_W  = 16;
    localparam int LIFE_W = 10;
    localparam int BKT_W  = 24;
    localparam int SUM_W  = 32;

    localparam logic [BKT_W-1:0] BKT_MAX = {BKT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // commands from controller to datapath
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_ADD,
        CMD_EXPIRE,
        CMD_SCAN
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_EXPIRE,
        ST_SCAN
    } t_state;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_done;
    } t_stat;

endpackage

// ----- sv/eesc_ctrl.sv -----
// controller state machine for the earliest expiry stock consumer
module eesc_ctrl
    import eesc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_IDLE;
        busy    = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd   = CMD_ADD;
                n_state = ST_EXPIRE;
            end
            ST_EXPIRE: begin
                o_cmd   = CMD_EXPIRE;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_stat.scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- sv/eesc_datapath.sv -----
// bucket ring, pointer, totals and result registers
module eesc_datapath
    import eesc_pkg::*;
#(
    parameter int HORIZON = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [CNT_W-1:0]  i_arrive_count,
    input  logic [LIFE_W-1:0] i_shelf_life,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic              o_consumed,
    output logic [SUM_W-1:0]  o_eaten_total,
    output logic [SUM_W-1:0]  o_stock_left
);

    localparam int AW = (HORIZON > 1) ? $clog2(HORIZON) : 1;
    localparam int XW = ((AW > LIFE_W) ? AW : LIFE_W) + 1;
    localparam int TW = BKT_W + AW;

    localparam logic [AW-1:0] H_LAST = AW'(HORIZON - 1);

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
        ring_inc = (x == H_LAST) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(HORIZON)) begin
            s = s - (AW+1)'(HORIZON);
        end
        ring_add = s[AW-1:0];
    endfunction

    // bucket memory
    logic [BKT_W-1:0] r_mem [HORIZON];
    logic [BKT_W-1:0] r_rdata;

    logic             w_en;
    logic [AW-1:0]    w_addr;
    logic [BKT_W-1:0] w_data;
    logic [AW-1:0]    rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control and payload registers
    logic [AW-1:0]    r_clr;
    logic [AW-1:0]    r_today;
    logic [AW-1:0]    r_ptr;
    logic [AW-1:0]    r_slot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_do_add;
    logic [TW-1:0]    r_total;
    logic [SUM_W-1:0] r_eaten;
    logic             r_valid;
    logic             r_consumed;

    logic [AW-1:0]    n_ptr;
    logic [TW-1:0]    n_total;
    logic [SUM_W-1:0] n_eaten;
    logic [AW-1:0]    n_today;
    logic             n_valid;
    logic             n_consumed;

    // shelf life clamped to the ring
    logic [XW-1:0]    life_x;
    logic [AW-1:0]    life_c;
    logic [AW-1:0]    slot;
    logic [AW-1:0]    ptr_dist;
    logic             add_ok;
    logic [BKT_W:0]   add_sum;
    logic [BKT_W-1:0] add_new;
    logic             total_zero;
    logic             rd_zero;

    always_comb begin
        life_x = XW'(i_shelf_life);
        if (life_x > XW'(HORIZON - 1)) begin
            life_x = XW'(HORIZON - 1);
        end
        life_c = life_x[AW-1:0];
        slot   = ring_add(r_today, life_c);
        if (r_ptr >= r_today) begin
            ptr_dist = r_ptr - r_today;
        end else begin
            ptr_dist = AW'((AW+1)'(r_ptr) + (AW+1)'(HORIZON) - (AW+1)'(r_today));
        end
        add_ok  = (life_c != '0) && (i_arrive_count != '0);
        add_sum = {1'b0, r_rdata} + (BKT_W+1)'(r_cnt);
        add_new = add_sum[BKT_W] ? BKT_MAX : add_sum[BKT_W-1:0];
        total_zero = (r_total == '0);
        rd_zero    = (r_rdata == '0);
    end

    always_comb begin
        w_en       = 1'b0;
        w_addr     = r_today;
        w_data     = '0;
        rd_addr    = r_ptr;
        n_ptr      = r_ptr;
        n_total    = r_total;
        n_eaten    = r_eaten;
        n_today    = r_today;
        n_valid    = 1'b0;
        n_consumed = r_consumed;
        o_stat     = '0;
        case (i_cmd)
            CMD_CLEAR: begin
                w_en            = 1'b1;
                w_addr          = r_clr;
                o_stat.clr_last = (r_clr == H_LAST);
            end
            CMD_LOAD: begin
                rd_addr = slot;
                // new stock ahead of the pointer pulls it back
                if (add_ok && (life_c < ptr_dist)) begin
                    n_ptr = slot;
                end
            end
            CMD_ADD: begin
                rd_addr = r_today;
                if (r_do_add) begin
                    w_en    = 1'b1;
                    w_addr  = r_slot;
                    w_data  = add_new;
                    n_total = r_total + TW'(add_new - r_rdata);
                end
            end
            CMD_EXPIRE: begin
                // today's bucket has expired
                w_en    = 1'b1;
                w_addr  = r_today;
                n_total = r_total - TW'(r_rdata);
                rd_addr = r_ptr;
            end
            CMD_SCAN: begin
                if (total_zero || !rd_zero) begin
                    o_stat.scan_done = 1'b1;
                    n_valid    = 1'b1;
                    n_consumed = !total_zero;
                    if (!total_zero) begin
                        w_en    = 1'b1;
                        w_addr  = r_ptr;
                        w_data  = r_rdata - BKT_W'(1);
                        n_total = r_total - TW'(1);
                        if (r_eaten != SUM_MAX) begin
                            n_eaten = r_eaten + SUM_W'(1);
                        end
                    end
                    n_today = ring_inc(r_today);
                    // pointer never sits on the current day
                    if (r_ptr == n_today) begin
                        n_ptr = ring_inc(n_today);
                    end
                end else begin
                    n_ptr   = ring_inc(r_ptr);
                    rd_addr = n_ptr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_today <= '0;
            r_ptr   <= AW'(1);
            r_total <= '0;
            r_eaten <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_CLEAR) begin
                r_clr <= ring_inc(r_clr);
            end
            r_today <= n_today;
            r_ptr   <= n_ptr;
            r_total <= n_total;
            r_eaten <= n_eaten;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_slot   <= slot;
            r_cnt    <= i_arrive_count;
            r_do_add <= add_ok;
        end
        r_consumed <= n_consumed;
    end

    generate
        if (TW > SUM_W) begin : g_sat
            assign o_stock_left = (r_total[TW-1:SUM_W] != '0) ? SUM_MAX
                                                              : r_total[SUM_W-1:0];
        end else begin : g_nosat
            assign o_stock_left = SUM_W'(r_total);
        end
    endgenerate

    assign o_valid       = r_valid;
    assign o_consumed    = r_consumed;
    assign o_eaten_total = r_eaten;

endmodule

// ----- sv/earliest_expiry_stock_consumer.sv -----
// top level of the earliest expiry stock consumer
//
// channel   signals                                       direction  handshake
// -------   -------                                       ---------  ---------
// tick      start, busy, i_arrive_count, i_shelf_life     in         start & !busy
// result    o_valid, o_consumed, o_eaten_total,           out        o_valid strobe
//           o_stock_left
//
// sequence: an accepted tick runs load, add, expire and scan, and the scan steps once for each
//   empty bucket the pointer walks over; the single bucket memory port pair
//   (one read, one write a cycle) sets this
// reset: a clearing pass writes every bucket to zero, busy high
// the strobe shows in the cycle busy drops, so the next word may be accepted
//   while the result is shown; the receiver cannot stall
module earliest_expiry_stock_consumer
    import eesc_pkg::*;
#(
    parameter int HORIZON = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CNT_W-1:0]  i_arrive_count,
    input  logic [LIFE_W-1:0] i_shelf_life,
    output logic              o_valid,
    output logic              o_consumed,
    output logic [SUM_W-1:0]  o_eaten_total,
    output logic [SUM_W-1:0]  o_stock_left
);

    // command and status between controller and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: clear pass, then load, add, expire, scan per word
    eesc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // bucket ring, earliest pointer and running totals
    eesc_datapath #(
        .HORIZON (HORIZON)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_arrive_count (i_arrive_count),
        .i_shelf_life   (i_shelf_life),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_consumed     (o_consumed),
        .o_eaten_total  (o_eaten_total),
        .o_stock_left   (o_stock_left)
    );

endmodule

// ----- sv/eesc_checker.sv -----
// port level checks for the earliest expiry stock consumer and their bind
module eesc_checker
    import eesc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic             o_consumed,
    input logic [SUM_W-1:0] o_eaten_total
);

    // a result only appears once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accept");

    // no result in the cycle after an accept
    a_accept_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result too soon after accept");

    // strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two strobes in a row");

    // a taken unit shows in the eaten count
    a_eaten_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_consumed) |-> (o_eaten_total != '0))
        else $error("unit taken but eaten count zero");

endmodule

bind earliest_expiry_stock_consumer eesc_checker u_eesc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_consumed    (o_consumed),
    .o_eaten_total (o_eaten_total)
);
